[design/ssort_pkg.sv]
`default_nettype none

package ssort_pkg;

  localparam int unsigned KEY_W = 16;
  localparam int unsigned POS_W = 4;

  // one stored entry: arrival position above the key
  typedef struct packed {
    logic [POS_W-1:0] pos;
    logic [KEY_W-1:0] key;
  } entry_t;

  localparam int unsigned ENTRY_W = $bits(entry_t);

  typedef enum logic [5:0] {
    S_IDLE = 6'b000001,  // waiting for an input word
    S_CMP  = 6'b000010,  // compare read entry, shift it up or drop key in
    S_INS  = 6'b000100,  // write key into slot 0
    S_RD   = 6'b001000,  // first read of the emit pass
    S_LD   = 6'b010000,  // load output register from read data
    S_OUT  = 6'b100000   // hold output word until taken
  } state_e;

endpackage

`default_nettype wire

[design/stable_insertion_sorter_top.sv]
// Channel   Dir  tdata (low bit up)                    tlast      tuser
// s_axis    in   [15:0] step_key                       is_last    -
// m_axis    out  [15:0] sorted_key, [19:16] orig pos,  run_end    overflowed
//                [23:20] zero
//
// Insertion moves each stored entry with a larger key up one slot, one entry
// per cycle through the single read port of the entry RAM (read, compare,
// write back one slot higher).
// Emission after the last word steps through RAM read, output register load
// and handshake for each entry, stalling while the sink holds m_axis_tready
// low. Input is held off during insertion and emission.
// Reset clears the entry count and overflow mark; the RAM needs no clearing,
// since only entries below the count are ever read.
// A stalled output word holds in its register until taken.
`default_nettype none

module stable_insertion_sorter_top #(
  parameter int unsigned MAX_ENTRIES = 16
) (
  input  wire         clk_i,
  input  wire         rst_ni,
  input  wire         s_axis_tvalid,
  output logic        s_axis_tready,
  input  wire  [15:0] s_axis_tdata,   // [15:0] step_key
  input  wire         s_axis_tlast,   // is_last
  output logic        m_axis_tvalid,
  input  wire         m_axis_tready,
  output logic [23:0] m_axis_tdata,   // [15:0] sorted_key, [19:16] original_position
  output logic        m_axis_tlast,   // run_end
  output logic        m_axis_tuser    // [0] overflowed
);

  localparam int unsigned AW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
  localparam int unsigned CW = $clog2(MAX_ENTRIES + 1);

  ssort_pkg::state_e state_q, state_d;

  logic [CW-1:0] count_q, count_d;    // stored entries
  logic          ovf_q, ovf_d;        // run dropped a word
  logic [AW-1:0] hole_q, hole_d;      // free slot during insertion
  logic [AW-1:0] idx_q, idx_d;        // emit pointer
  logic [ssort_pkg::KEY_W-1:0] key_q, key_d;
  logic          last_q, last_d;

  ssort_pkg::entry_t out_q, out_d;
  logic          out_end_q, out_end_d;

  logic          we;
  logic [AW-1:0] waddr, raddr;
  ssort_pkg::entry_t wdata, rdata;
  logic          full, accept, greater, emit_end, out_take;

  ssort_ram #(
    .WIDTH(ssort_pkg::ENTRY_W),
    .DEPTH(MAX_ENTRIES)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (we),
    .waddr_i(waddr),
    .wdata_i(wdata),
    .raddr_i(raddr),
    .rdata_o(rdata)
  );

  assign full     = (count_q == CW'(MAX_ENTRIES));
  assign accept   = s_axis_tvalid && s_axis_tready;
  assign greater  = (rdata.key > key_q);
  assign emit_end = ((CW'(idx_q) + CW'(1)) == count_q);
  assign out_take = m_axis_tvalid && m_axis_tready;

  always_comb begin
    state_d   = state_q;
    count_d   = count_q;
    ovf_d     = ovf_q;
    hole_d    = hole_q;
    idx_d     = idx_q;
    key_d     = key_q;
    last_d    = last_q;
    out_d     = out_q;
    out_end_d = out_end_q;
    we        = 1'b0;
    waddr     = hole_q;
    wdata     = '{pos: ssort_pkg::POS_W'(count_q), key: key_q};
    raddr     = idx_q;

    case (state_q)
      ssort_pkg::S_IDLE: begin
        if (accept) begin
          key_d  = s_axis_tdata;
          last_d = s_axis_tlast;
          if (full) begin
            ovf_d = 1'b1;
            if (s_axis_tlast) begin
              idx_d   = '0;
              state_d = ssort_pkg::S_RD;
            end
          end else begin
            hole_d = count_q[AW-1:0];
            if (count_q == '0) begin
              state_d = ssort_pkg::S_INS;
            end else begin
              raddr   = count_q[AW-1:0] - AW'(1);
              state_d = ssort_pkg::S_CMP;
            end
          end
        end
      end
      ssort_pkg::S_CMP: begin
        we = 1'b1;
        if (greater) begin
          // shift the larger entry up one slot
          wdata  = rdata;
          hole_d = hole_q - AW'(1);
          if (hole_q == AW'(1)) begin
            state_d = ssort_pkg::S_INS;
          end else begin
            raddr = hole_q - AW'(2);
          end
        end else begin
          count_d = count_q + CW'(1);
          idx_d   = '0;
          state_d = last_q ? ssort_pkg::S_RD : ssort_pkg::S_IDLE;
        end
      end
      ssort_pkg::S_INS: begin
        we      = 1'b1;
        count_d = count_q + CW'(1);
        idx_d   = '0;
        state_d = last_q ? ssort_pkg::S_RD : ssort_pkg::S_IDLE;
      end
      ssort_pkg::S_RD: begin
        state_d = ssort_pkg::S_LD;
      end
      ssort_pkg::S_LD: begin
        out_d     = rdata;
        out_end_d = emit_end;
        state_d   = ssort_pkg::S_OUT;
      end
      ssort_pkg::S_OUT: begin
        if (out_take) begin
          if (out_end_q) begin
            count_d = '0;
            ovf_d   = 1'b0;
            state_d = ssort_pkg::S_IDLE;
          end else begin
            idx_d   = idx_q + AW'(1);
            raddr   = idx_q + AW'(1);
            state_d = ssort_pkg::S_LD;
          end
        end
      end
      default: begin
        state_d = ssort_pkg::S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ssort_pkg::S_IDLE;
      count_q <= '0;
      ovf_q   <= 1'b0;
      idx_q   <= '0;
      last_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      ovf_q   <= ovf_d;
      idx_q   <= idx_d;
      last_q  <= last_d;
    end
  end

  // payload registers, no reset
  always_ff @(posedge clk_i) begin
    hole_q    <= hole_d;
    key_q     <= key_d;
    out_q     <= out_d;
    out_end_q <= out_end_d;
  end

  assign s_axis_tready = (state_q == ssort_pkg::S_IDLE);
  assign m_axis_tvalid = (state_q == ssort_pkg::S_OUT);
  assign m_axis_tdata  = {4'b0000, out_q.pos, out_q.key};
  assign m_axis_tlast  = out_end_q;
  assign m_axis_tuser  = ovf_q;

endmodule

`default_nettype wire

[design/ssort_ram.sv]
`default_nettype none

module ssort_ram #(
  parameter int unsigned WIDTH = 20,
  parameter int unsigned DEPTH = 16
) (
  input  wire                     clk_i,
  input  wire                     we_i,
  input  wire [$clog2(DEPTH)-1:0] waddr_i,
  input  wire [WIDTH-1:0]         wdata_i,
  input  wire [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]        rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

`default_nettype wire

[design/ssort_checker.sv]
`default_nettype none

module ssort_checker (
  input wire        clk_i,
  input wire        rst_ni,
  input wire        s_axis_tvalid,
  input wire        s_axis_tready,
  input wire        s_axis_tlast,
  input wire        m_axis_tvalid,
  input wire        m_axis_tready,
  input wire [23:0] m_axis_tdata,
  input wire        m_axis_tlast,
  input wire        m_axis_tuser
);

  // input is never taken while an output word is pending
  a_no_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(s_axis_tready && m_axis_tvalid))
    else $error("input ready while output word pending");

  // after the last word of a run is taken, no output word is offered in the next cycle
  a_end_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tready && m_axis_tlast) |=> !m_axis_tvalid)
    else $error("output continued after run end");

  // a run-closing input word is inserted (or dropped on overflow) before emission, so input closes
  a_last_blocks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready && s_axis_tlast) |=> !s_axis_tready)
    else $error("input reopened right after last word");

  // stalled output word holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tready) |=>
      (m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast)
       && $stable(m_axis_tuser)))
    else $error("stalled output word changed");

endmodule

bind stable_insertion_sorter_top ssort_checker u_ssort_checker (.*);

`default_nettype wire
